// ===== rtl/core/sorted_key_table_defines.svh =====
// Assertion macros for the sorted key table.
// Depends on a clock named clk and a reset named rst in the asserting module.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SKT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted key table: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key table: next-cycle check failed");

`endif

// ===== rtl/core/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// No dependencies.
`default_nettype none

package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 2;
  localparam int POS_W    = $clog2(CAPACITY);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic                    del_en;
    logic signed [KEY_W-1:0] key;
  } skt_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/skt_cell.sv =====
// One slot of the key chain: holds a key and its compare flags.
// Depends on skt_pkg.
`default_nettype none

module skt_cell (
  input  wire                           clk,
  input  skt_pkg::skt_op_t              op,
  input  wire                           used,
  input  wire                           low_le,
  input  wire signed [skt_pkg::KEY_W-1:0] low_data,
  input  wire signed [skt_pkg::KEY_W-1:0] high_data,
  output logic signed [skt_pkg::KEY_W-1:0] data,
  output logic                          lt,
  output logic                          le,
  output logic                          eq
);
  import skt_pkg::*;

  // Latch compare flags; empty slots count as above every key
  always_ff @(posedge clk) begin
    if (op.cmp_en) begin
      lt <= used && (data <  op.key);
      le <= used && (data <= op.key);
      eq <= used && (data == op.key);
    end
  end

  // Shift up on insert, down on delete, or hold
  always_ff @(posedge clk) begin
    if (op.ins_en && !le) begin
      data <= low_le ? op.key : low_data;
    end else if (op.del_en && !lt) begin
      data <= high_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/skt_rank.sv =====
// Converts a thermometer of per-slot flags into the number of set slots.
// Depends on skt_pkg.
`default_nettype none

module skt_rank (
  input  wire [skt_pkg::CAPACITY-1:0] flags,
  output logic [skt_pkg::CNT_W-1:0]   rank
);
  import skt_pkg::*;

  logic [CAPACITY:0] edge_hit;

  // Mark the slot where the thermometer ends
  always_comb begin
    for (int i = 0; i <= CAPACITY; i++) begin
      edge_hit[i] = ((i == 0) ? 1'b1 : flags[(i == 0) ? 0 : i - 1]) &
                    ((i == CAPACITY) ? 1'b1 : !flags[(i == CAPACITY) ? 0 : i]);
    end
  end

  // Encode the one-hot edge into an index
  always_comb begin
    rank = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (edge_hit[i]) rank = rank | CNT_W'(i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_table.sv =====
// Top level of the sorted key table: control sequencer, cell chain, rank encoders.
// Depends on skt_pkg, skt_cell, skt_rank and sorted_key_table_defines.svh.
`default_nettype none
`include "sorted_key_table_defines.svh"

// Keeps up to CAPACITY signed keys in ascending order. Pulse start with mode and
// key while busy is low. Each command passes through the accept cycle, a
// compare cycle in which every cell checks its key against the command key, and
// an update cycle in which cells shift in one step; done then pulses for one
// cycle with ok, position and count, and must be taken in that cycle. busy is
// high for the compare and update cycles, so a new command cannot be accepted
// until the update is done; it can be issued in the cycle in which done is high.
module sorted_key_table (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [skt_pkg::MODE_W-1:0]    mode,
  input  wire signed [skt_pkg::KEY_W-1:0] key,
  output logic                         done,
  output logic                         ok,
  output logic [skt_pkg::POS_W-1:0]    position,
  output logic [skt_pkg::CNT_W-1:0]    count
);
  import skt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [MODE_W-1:0]       cmd_mode;
  logic signed [KEY_W-1:0] cmd_key;
  logic [CNT_W-1:0]        element_count;
  logic [CNT_W-1:0]        element_count_next;

  skt_op_t                 op;
  logic signed [KEY_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]     lt_flags;
  logic [CAPACITY-1:0]     le_flags;
  logic [CAPACITY-1:0]     eq_flags;
  logic [CNT_W-1:0]        rank_lt;
  logic [CNT_W-1:0]        rank_le;
  logic                    found;
  logic                    do_ins;
  logic                    do_del;
  logic                    apply;

  assign busy  = (state != ST_IDLE);
  assign apply = (state == ST_APPLY);
  assign found = |eq_flags;
  assign do_ins = apply && (cmd_mode == MODE_INSERT) && (element_count < CNT_W'(CAPACITY));
  assign do_del = apply && (cmd_mode == MODE_DELETE) && found;

  // Sequence accept, compare and update
  always_comb begin
    case (state)
      ST_IDLE:  state_next = (start) ? ST_CMP : ST_IDLE;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_mode <= mode;
      cmd_key  <= key;
    end
  end

  // Broadcast the operation to the chain
  always_comb begin
    op.cmp_en = (state == ST_CMP);
    op.ins_en = do_ins;
    op.del_en = do_del;
    op.key    = cmd_key;
  end

  // Chain of cells, each inner cell talking to its two neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    used;
    logic                    low_le;
    logic signed [KEY_W-1:0] low_data;
    logic signed [KEY_W-1:0] high_data;

    assign used      = (CNT_W'(g) < element_count);
    assign low_le    = (g == 0) ? 1'b1 : le_flags[(g == 0) ? 0 : g - 1];
    assign low_data  = cell_data[(g == 0) ? 0 : g - 1];
    assign high_data = cell_data[(g == CAPACITY - 1) ? g : g + 1];

    skt_cell u_cell (
      .clk       (clk),
      .op        (op),
      .used      (used),
      .low_le    (low_le),
      .low_data  (low_data),
      .high_data (high_data),
      .data      (cell_data[g]),
      .lt        (lt_flags[g]),
      .le        (le_flags[g]),
      .eq        (eq_flags[g])
    );
  end

  skt_rank u_rank_lt (
    .flags (lt_flags),
    .rank  (rank_lt)
  );

  skt_rank u_rank_le (
    .flags (le_flags),
    .rank  (rank_le)
  );

  // Track the number of stored keys
  always_comb begin
    element_count_next = element_count;
    if (do_ins) element_count_next = element_count + 1'b1;
    else if (do_del) element_count_next = element_count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else begin
      element_count <= element_count_next;
    end
  end

  // Pulse done for one cycle after the update
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      count <= element_count_next;
      if (do_ins) begin
        ok       <= 1'b1;
        position <= rank_le[POS_W-1:0];
      end else if (found && (cmd_mode == MODE_DELETE || cmd_mode == MODE_SEARCH)) begin
        ok       <= 1'b1;
        position <= rank_lt[POS_W-1:0];
      end else begin
        ok       <= 1'b0;
        position <= '0;
      end
    end
  end

  `SKT_ASSERT_IMPL(a_count_bound, 1'b1, element_count <= CNT_W'(CAPACITY))
  `SKT_ASSERT_NEXT(a_done_after_apply, apply, done)
  `SKT_ASSERT_IMPL(a_fail_pos_zero, done && !ok, position == '0)
  `SKT_ASSERT_NEXT(a_insert_grows, do_ins, element_count == CNT_W'($past(element_count) + 1'b1))
  `SKT_ASSERT_NEXT(a_accept_compare, start && !busy, state == ST_CMP)

endmodule

`default_nettype wire
